### design/scan_line_tone_to_bgr24_macros.svh
// Assertion macros shared by the scan line tone packer modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SCAN_LINE_TONE_TO_BGR24_MACROS_SVH
`define SCAN_LINE_TONE_TO_BGR24_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLBGR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SLBGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLBGR_ASSERT_IMPL(label, ante, cons, msg)
`define SLBGR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/slbgr_pkg.sv
// Package for the scan line tone packer: register codes, constants, shared types.
// No dependencies.
package slbgr_pkg;

  localparam int unsigned CMD_DEPTH = 4;

  localparam int TONE_MID       = 255000;
  localparam int TONE_FULL      = 510000;
  localparam int TONE_ROUND     = 1000;
  localparam int TONE_GAIN_BASE = 1000;

  localparam int unsigned RECIP_3          = 43691;
  localparam int unsigned RECIP_3_SHIFT    = 17;
  localparam int unsigned RECIP_125        = 33555;
  localparam int unsigned RECIP_125_SHIFT  = 22;

  typedef enum logic [2:0] {
    REG_GRAY_MODE   = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_CONTRAST    = 3'd2,
    REG_LINE_BYTES  = 3'd3,
    REG_LINE_PIXELS = 3'd4,
    REG_LINE_COUNT  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        gray_mode;
    logic [15:0] line_bytes;
    logic [14:0] line_pixels;
    logic [15:0] line_count;
  } geom_cfg_t;

  typedef struct packed {
    logic signed [10:0] brightness_offset;
    logic signed [10:0] contrast_gain;
  } tone_cfg_t;

  typedef struct packed {
    logic [7:0] smp0;
    logic [7:0] smp1;
    logic [7:0] smp2;
    logic       has_tone;
    logic [2:0] n_ops;
    logic       frame_done;
    logic       overflow;
  } cmd_t;

  typedef struct packed {
    logic tone;
    logic last;
    logic frame_done;
    logic overflow;
  } op_flags_t;

endpackage

### design/slbgr_in_if.sv
// Input byte channel of the scan line tone packer.
// Stand-alone; carries valid, ready and the input payload.
interface slbgr_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] sample_byte;

  modport source (output valid, frame_start, sample_byte, input ready);
  modport sink (input valid, frame_start, sample_byte, output ready);
endinterface

### design/slbgr_out_if.sv
// Output byte channel of the scan line tone packer.
// Stand-alone; carries valid, ready and the result payload.
interface slbgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;
  logic       overflow_error;

  modport source (output valid, out_byte, run_last, frame_done, overflow_error, input ready);
  modport sink (input valid, out_byte, run_last, frame_done, overflow_error, output ready);
endinterface

### design/scan_line_tone_to_bgr24.sv
// Top level of the scan line tone packer: configuration registers, front end,
// command queue and back end. Depends on slbgr_pkg, slbgr_in_if, slbgr_out_if.
//
//   port       dir  handshake      payload
//   px_in_i    in   valid/ready    frame_start, sample_byte
//   px_out_o   out  valid/ready    out_byte, run_last, frame_done, overflow_error
//   cfg_*      in   cfg_we_i       cfg_addr_i (register), cfg_wdata_i
//
// An input byte is taken each cycle while the command queue (CmdDepth entries) has room.
// The back end emits one byte a cycle while the output is not stalled: three bytes per gray
// pixel or color triplet, plus one per line pad byte; an issued byte passes p1, p2 and p3 to the output.
// Reset clears counters, held samples and the queue; registers take their defaults.
// A stalled output freezes the tone pipeline; input ready drops only when the queue fills.
module scan_line_tone_to_bgr24 import slbgr_pkg::*; #(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  slbgr_in_if.sink    px_in_i,
  slbgr_out_if.source px_out_o
);

  logic               gray_mode_q;
  logic signed [10:0] brightness_offset_q;
  logic signed [10:0] contrast_gain_q;
  logic [15:0]        line_bytes_q;
  logic [14:0]        line_pixels_q;
  logic [15:0]        line_count_q;

  geom_cfg_t geom;
  tone_cfg_t tone;
  logic      cmd_push;
  cmd_t      cmd_wr;
  logic      cmd_full;
  logic      cmd_pop;
  cmd_t      cmd_head;
  logic      cmd_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_mode_q         <= 1'b0;
      brightness_offset_q <= '0;
      contrast_gain_q     <= '0;
      line_bytes_q        <= 16'd3;
      line_pixels_q       <= 15'd1;
      line_count_q        <= 16'd1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_GRAY_MODE:   gray_mode_q         <= cfg_wdata_i[0];
        REG_BRIGHTNESS:  brightness_offset_q <= $signed(cfg_wdata_i[10:0]);
        REG_CONTRAST:    contrast_gain_q     <= $signed(cfg_wdata_i[10:0]);
        REG_LINE_BYTES:  line_bytes_q        <= cfg_wdata_i;
        REG_LINE_PIXELS: line_pixels_q       <= cfg_wdata_i[14:0];
        REG_LINE_COUNT:  line_count_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign geom.gray_mode         = gray_mode_q;
  assign geom.line_bytes        = line_bytes_q;
  assign geom.line_pixels       = line_pixels_q;
  assign geom.line_count        = line_count_q;
  assign tone.brightness_offset = brightness_offset_q;
  assign tone.contrast_gain     = contrast_gain_q;

  slbgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (px_in_i),
    .geom_i     (geom),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  slbgr_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_wr),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .head_o      (cmd_head),
    .empty_o     (cmd_empty)
  );

  slbgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tone_i      (tone),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_o       (px_out_o)
  );

endmodule

### design/slbgr_front.sv
// Front end: accepts input bytes, tracks line position and lines, classifies each byte
// into a command for the back end. Depends on slbgr_pkg and slbgr_in_if.
module slbgr_front import slbgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slbgr_in_if.sink   in_i,
  input  geom_cfg_t  geom_i,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic [15:0] byte_in_line_q, byte_in_line_d;
  logic [15:0] line_index_q, line_index_d;
  logic [1:0]  phase_q, phase_d;
  logic [14:0] pix_k_q, pix_k_d;
  logic [7:0]  held_red_q, held_red_d;
  logic [7:0]  held_green_q, held_green_d;

  logic [15:0] lb;
  logic [14:0] lp;
  logic [32:0] div3_prod;
  logic [14:0] lb_div3;
  logic [1:0]  pix_mod4;
  logic        accept;
  logic [15:0] pos;
  logic [15:0] line;
  logic [15:0] pstart;
  logic [1:0]  phase;
  logic [14:0] pix_k;
  logic        ovf;
  logic        gray_in;
  logic        color_in;
  logic        in_px;
  logic        emit;
  logic        eol;
  logic        fd;
  logic [1:0]  pad;
  logic [2:0]  n_ops;

  assign in_i.ready = !cmd_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign lb        = (geom_i.line_bytes == '0) ? 16'd1 : geom_i.line_bytes;
  assign lp        = (geom_i.line_pixels == '0) ? 15'd1 : geom_i.line_pixels;
  assign div3_prod = 33'(lb) * 33'(RECIP_3);
  assign lb_div3   = div3_prod[RECIP_3_SHIFT +: 15];

  always_comb begin
    if (geom_i.gray_mode) begin
      pix_mod4 = ({1'b0, lp} < lb) ? lp[1:0] : lb[1:0];
    end else begin
      pix_mod4 = (lb_div3 < lp) ? lb_div3[1:0] : lp[1:0];
    end

    pos    = in_i.frame_start ? '0 : byte_in_line_q;
    line   = in_i.frame_start ? '0 : line_index_q;
    phase  = in_i.frame_start ? '0 : phase_q;
    pix_k  = in_i.frame_start ? '0 : pix_k_q;
    pstart = pos - {14'd0, phase};

    ovf      = line >= geom_i.line_count;
    gray_in  = ({1'b0, pos} < {2'b00, lp}) && (pos < lb);
    color_in = (pix_k < lp) && (({1'b0, pstart} + 17'd3) <= {1'b0, lb});
    in_px    = geom_i.gray_mode ? gray_in : color_in;
    emit     = in_px && (geom_i.gray_mode || phase == 2'd2);
    eol      = ({1'b0, pos} + 17'd1) >= {1'b0, lb};
    pad      = eol ? pix_mod4 : 2'd0;
    fd       = !ovf && eol && (({1'b0, line} + 17'd1) == {1'b0, geom_i.line_count});
    n_ops    = ovf ? 3'd1 : ((emit ? 3'd3 : 3'd0) + {1'b0, pad});

    cmd_o.smp0       = in_i.sample_byte;
    cmd_o.smp1       = geom_i.gray_mode ? in_i.sample_byte : held_green_q;
    cmd_o.smp2       = geom_i.gray_mode ? in_i.sample_byte : held_red_q;
    cmd_o.has_tone   = !ovf && emit;
    cmd_o.n_ops      = n_ops;
    cmd_o.frame_done = fd;
    cmd_o.overflow   = ovf;
    cmd_push_o       = accept && (n_ops != 3'd0);

    byte_in_line_d = byte_in_line_q;
    line_index_d   = line_index_q;
    phase_d        = phase_q;
    pix_k_d        = pix_k_q;
    held_red_d     = held_red_q;
    held_green_d   = held_green_q;
    if (accept) begin
      byte_in_line_d = pos;
      line_index_d   = line;
      phase_d        = phase;
      pix_k_d        = pix_k;
      if (!ovf) begin
        if (!geom_i.gray_mode && in_px) begin
          if (phase == 2'd0) begin
            held_red_d = in_i.sample_byte;
          end else if (phase == 2'd1) begin
            held_green_d = in_i.sample_byte;
          end
        end
        if (eol) begin
          byte_in_line_d = '0;
          line_index_d   = line + 16'd1;
          phase_d        = '0;
          pix_k_d        = '0;
        end else begin
          byte_in_line_d = pos + 16'd1;
          phase_d        = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          pix_k_d        = (phase == 2'd2) ? pix_k + 15'd1 : pix_k;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_line_q <= '0;
      line_index_q   <= '0;
      phase_q        <= '0;
      pix_k_q        <= '0;
      held_red_q     <= '0;
      held_green_q   <= '0;
    end else begin
      byte_in_line_q <= byte_in_line_d;
      line_index_q   <= line_index_d;
      phase_q        <= phase_d;
      pix_k_q        <= pix_k_d;
      held_red_q     <= held_red_d;
      held_green_q   <= held_green_d;
    end
  end

endmodule

### design/slbgr_cmd_fifo.sv
// Command queue between front and back end, registers indexed by read and write pointer.
// Depends on slbgr_pkg and the assertion macros header.
`include "scan_line_tone_to_bgr24_macros.svh"

module slbgr_cmd_fifo import slbgr_pkg::*; #(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en;
  logic            rd_en;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SLBGR_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count above depth")
  `SLBGR_ASSERT_IMPL(a_empty_ptrs, empty_o, wr_ptr_q == rd_ptr_q, "empty queue with apart pointers")
  `SLBGR_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_q == $past(count_q) + 1'b1, "count missed push")

endmodule

### design/slbgr_back.sv
// Back end: steps through each command one output byte a cycle unless the output stalls, runs
// samples through a three-stage tone pipeline ending in the output register. Depends on slbgr_pkg.
`include "scan_line_tone_to_bgr24_macros.svh"

module slbgr_back import slbgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tone_cfg_t   tone_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  slbgr_out_if.source out_o
);

  logic [2:0]         idx_q, idx_d;
  logic               p1_valid_q, p2_valid_q, p3_valid_q;
  op_flags_t          p1_flags_q, p2_flags_q;
  logic signed [22:0] p1_prod_q;
  logic               p2_lo_q, p2_hi_q;
  logic [14:0]        p2_y_q;
  logic [7:0]         p3_byte_q;
  op_flags_t          p3_flags_q;

  logic               adv;
  logic               issue;
  logic               last_op;
  logic [7:0]         smp;
  logic signed [10:0] dev;
  logic signed [11:0] gain;
  logic signed [22:0] prod;
  op_flags_t          iss_flags;
  logic signed [22:0] bright_ext;
  logic signed [22:0] n_val;
  logic signed [22:0] n_rnd;
  logic [30:0]        q_prod;
  logic [7:0]         tone_byte;

  assign adv       = !p3_valid_q || out_o.ready;
  assign issue     = adv && cmd_valid_i;
  assign last_op   = idx_q == (cmd_i.n_ops - 3'd1);
  assign cmd_pop_o = issue && last_op;
  assign idx_d     = issue ? (last_op ? 3'd0 : idx_q + 3'd1) : idx_q;

  always_comb begin
    case (idx_q)
      3'd0:    smp = cmd_i.smp0;
      3'd1:    smp = cmd_i.smp1;
      default: smp = cmd_i.smp2;
    endcase
    iss_flags.tone       = cmd_i.has_tone && (idx_q < 3'd3);
    iss_flags.last       = last_op;
    iss_flags.frame_done = last_op && cmd_i.frame_done;
    iss_flags.overflow   = cmd_i.overflow;
  end

  assign dev  = $signed({2'b00, smp, 1'b0}) - 11'sd255;
  assign gain = $signed({tone_i.contrast_gain[10], tone_i.contrast_gain})
              + 12'(TONE_GAIN_BASE);
  assign prod = 23'(dev) * 23'(gain);

  assign bright_ext = 23'(tone_i.brightness_offset);
  assign n_val      = p1_prod_q + 23'(TONE_MID) + (bright_ext <<< 9) - (bright_ext <<< 1);
  assign n_rnd      = n_val + 23'(TONE_ROUND);

  assign q_prod    = 31'(p2_y_q) * 31'(RECIP_125);
  assign tone_byte = (!p2_flags_q.tone || p2_lo_q) ? 8'd0 :
                     p2_hi_q ? 8'd255 : q_prod[RECIP_125_SHIFT +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) begin
        p1_valid_q <= issue;
        p2_valid_q <= p1_valid_q;
        p3_valid_q <= p2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_flags_q <= iss_flags;
      p1_prod_q  <= prod;
      p2_flags_q <= p1_flags_q;
      p2_lo_q    <= n_val <= 23'sd0;
      p2_hi_q    <= n_val >= 23'(TONE_FULL);
      p2_y_q     <= n_rnd[18:4];
      p3_flags_q <= p2_flags_q;
      p3_byte_q  <= tone_byte;
    end
  end

  assign out_o.valid          = p3_valid_q;
  assign out_o.out_byte       = p3_byte_q;
  assign out_o.run_last       = p3_flags_q.last;
  assign out_o.frame_done     = p3_flags_q.frame_done;
  assign out_o.overflow_error = p3_flags_q.overflow;

  `SLBGR_ASSERT_IMPL(a_ovf_shape, out_o.valid && out_o.overflow_error,
                     out_o.run_last && out_o.out_byte == 8'd0 && !out_o.frame_done,
                     "overflow result malformed")
  `SLBGR_ASSERT_IMPL(a_fd_last, out_o.valid && out_o.frame_done, out_o.run_last,
                     "frame done off last result")
  `SLBGR_ASSERT_IMPL(a_idx_idle, !cmd_valid_i, idx_q == 3'd0, "op index moved without command")

endmodule

### verif/tb_scan_line_tone_to_bgr24.sv
// Testbench for scan_line_tone_to_bgr24: tone curve, BGR packing, line padding and overflow.
// Uses slbgr_pkg, slbgr_in_if and slbgr_out_if; predicts each output byte and checks it in order.
`timescale 1ns / 100ps

module tb_scan_line_tone_to_bgr24 import slbgr_pkg::*;;

  localparam int SettleCycles  = 24;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic       overflow_error;
  } bgr_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  slbgr_in_if  px_in ();
  slbgr_out_if px_out ();

  scan_line_tone_to_bgr24 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .px_in_i    (px_in),
    .px_out_o   (px_out)
  );

  bgr_res_t bgr_expected_q[$];

  logic               cfg_gray;
  logic signed [10:0] cfg_bright;
  logic signed [10:0] cfg_contr;
  logic [15:0]        cfg_lbytes;
  logic [14:0]        cfg_lpix;
  logic [15:0]        cfg_lcount;

  logic [15:0] col_pos;
  logic [15:0] line_no;
  logic [7:0]  held_r;
  logic [7:0]  held_g;

  int src_gap_pct;
  int snk_gap_pct;
  int items_sent;
  int items_taken;
  int overflows;
  int bytes_checked;
  int frames_done;
  int configs_loaded;
  int mismatches;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] tone_of(input logic [7:0] s);
    int n;
    n = (2 * int'(s) - 255) * (1000 + int'(cfg_contr)) + 255000 + 510 * int'(cfg_bright);
    if (n <= 0) return 8'h00;
    if (n >= 510000) return 8'hFF;
    return 8'((n + 1000) / 2000);
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic predict_byte(input logic fs, input logic [7:0] s, output bit taken);
    int unsigned lb, lp, bpp, pix, pixbytes, stride, pos, pad;
    logic [7:0] line_q[$];
    bit last_line;
    bgr_res_t r;
    taken = 1'b0;
    last_line = 1'b0;
    if (fs) begin
      col_pos = '0;
      line_no = '0;
    end
    if (line_no >= cfg_lcount) begin
      r = '{out_byte: 8'h00, run_last: 1'b1, frame_done: 1'b0, overflow_error: 1'b1};
      bgr_expected_q.push_back(r);
      overflows++;
      taken = 1'b1;
      return;
    end
    lb = (cfg_lbytes == 0) ? 1 : cfg_lbytes;
    lp = (cfg_lpix == 0) ? 1 : cfg_lpix;
    bpp = cfg_gray ? 1 : 3;
    pix = lb / bpp;
    if (lp < pix) pix = lp;
    pixbytes = pix * bpp;
    stride = (pix * 3 + 3) & ~32'd3;
    pos = col_pos;
    if (pos < pixbytes) begin
      taken = 1'b1;
      if (cfg_gray) begin
        repeat (3) line_q.push_back(tone_of(s));
      end else begin
        case (pos % 3)
          0: held_r = s;
          1: held_g = s;
          default: begin
            line_q.push_back(tone_of(s));
            line_q.push_back(tone_of(held_g));
            line_q.push_back(tone_of(held_r));
          end
        endcase
      end
    end
    if (pos + 1 >= lb) begin
      pad = stride - pix * 3;
      repeat (pad) line_q.push_back(8'h00);
      last_line = (line_no + 1 == cfg_lcount);
      line_no = line_no + 16'd1;
      col_pos = '0;
    end else begin
      col_pos = 16'(pos + 1);
    end
    for (int i = 0; i < line_q.size(); i++) begin
      r.out_byte       = line_q[i];
      r.run_last       = (i == line_q.size() - 1);
      r.frame_done     = last_line && (i == line_q.size() - 1);
      r.overflow_error = 1'b0;
      bgr_expected_q.push_back(r);
    end
  endtask

  task automatic send_byte(input logic fs, input logic [7:0] s);
    bit taken;
    while ($urandom_range(99) < src_gap_pct) begin
      px_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    px_in.valid       <= 1'b1;
    px_in.frame_start <= fs;
    px_in.sample_byte <= s;
    predict_byte(fs, s, taken);
    items_sent++;
    if (taken) items_taken++;
    @(posedge clk_i);
    while (!px_in.ready) @(posedge clk_i);
  endtask

  task automatic settle();
    px_in.valid <= 1'b0;
    while (bgr_expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GRAY_MODE:   cfg_gray   = val[0];
      REG_BRIGHTNESS:  cfg_bright = val[10:0];
      REG_CONTRAST:    cfg_contr  = val[10:0];
      REG_LINE_BYTES:  cfg_lbytes = val;
      REG_LINE_PIXELS: cfg_lpix   = val[14:0];
      REG_LINE_COUNT:  cfg_lcount = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic g, input int bri, input int con,
                             input int lb, input int lp, input int lc);
    settle();
    put_reg(REG_GRAY_MODE, 16'(g));
    put_reg(REG_BRIGHTNESS, 16'(bri) & 16'h07FF);
    put_reg(REG_CONTRAST, 16'(con) & 16'h07FF);
    put_reg(REG_LINE_BYTES, 16'(lb));
    put_reg(REG_LINE_PIXELS, 16'(lp) & 16'h7FFF);
    put_reg(REG_LINE_COUNT, 16'(lc));
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  task automatic test_reset_defaults();
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h5A);
  endtask

  task automatic test_tone_clamps();
    load_config(1'b1, 1000, -1000, 3, 2, 1);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h7F);
    load_config(1'b1, -1000, 1000, 2, 1, 1);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hFF);
  endtask

  task automatic test_zero_sizes();
    load_config(1'b1, 0, 0, 0, 0, 1);
    send_byte(1'b1, 8'hC3);
    load_config(1'b0, 0, 0, 0, 0, 1);
    send_byte(1'b1, 8'h11);
    send_byte(1'b0, 8'h22);
    load_config(1'b1, 0, 0, 4, 1, 0);
    send_byte(1'b1, 8'h33);
  endtask

  task automatic test_config_mid_line();
    load_config(1'b0, 300, -200, 65535, 21845, 65535);
    send_byte(1'b1, 8'h10);
    send_byte(1'b0, 8'h20);
    load_config(1'b0, 300, -200, 3, 21845, 1);
    send_byte(1'b0, 8'h30);
    send_byte(1'b0, 8'h40);
  endtask

  task automatic run_random_frames(input int n_items, input int src_pct, input int snk_pct);
    int sent0, bri, con, lb, lp, lc, nbytes;
    src_gap_pct = src_pct;
    snk_gap_pct = snk_pct;
    sent0 = items_sent;
    while (items_sent - sent0 < n_items) begin
      bri = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 1000 : -1000)
                                     : int'($urandom_range(2000)) - 1000;
      con = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 1000 : -1000)
                                     : int'($urandom_range(2000)) - 1000;
      lb = ($urandom_range(5) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      lp = ($urandom_range(9) == 0) ? 21845 : $urandom_range(6, 1);
      lc = $urandom_range(3, 1);
      load_config(1'($urandom_range(1)), bri, con, lb, lp, lc);
      nbytes = lb * lc;
      repeat ($urandom_range(2, 1)) begin
        for (int i = 0; i < nbytes; i++) begin
          if (items_sent - sent0 >= n_items) break;
          if (i > 0 && $urandom_range(99) < 3) break;
          send_byte(i == 0 || $urandom_range(99) < 2, rand_sample());
        end
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(2, 1)) send_byte(1'b0, rand_sample());
      end
    end
  endtask

  always @(posedge clk_i) begin
    px_out.ready <= ($urandom_range(99) >= snk_gap_pct);
  end

  always @(posedge clk_i) begin
    bgr_res_t want;
    if (rst_ni && px_out.valid && px_out.ready) begin
      if (bgr_expected_q.size() == 0) begin
        report_mismatch("unexpected output byte", px_out.out_byte, -1);
      end else begin
        want = bgr_expected_q.pop_front();
        bytes_checked++;
        if (want.frame_done) frames_done++;
        if (px_out.out_byte !== want.out_byte)
          report_mismatch("out_byte", px_out.out_byte, want.out_byte);
        if (px_out.run_last !== want.run_last)
          report_mismatch("run_last", px_out.run_last, want.run_last);
        if (px_out.frame_done !== want.frame_done)
          report_mismatch("frame_done", px_out.frame_done, want.frame_done);
        if (px_out.overflow_error !== want.overflow_error)
          report_mismatch("overflow_error", px_out.overflow_error, want.overflow_error);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (px_in.valid && px_in.ready) || (px_out.valid && px_out.ready)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $realtime, stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = REG_GRAY_MODE;
    cfg_wdata         = '0;
    px_in.valid       = 1'b0;
    px_in.frame_start = 1'b0;
    px_in.sample_byte = '0;
    px_out.ready      = 1'b0;
    cfg_gray          = 1'b0;
    cfg_bright        = '0;
    cfg_contr         = '0;
    cfg_lbytes        = 16'd3;
    cfg_lpix          = 15'd1;
    cfg_lcount        = 16'd1;
    col_pos           = '0;
    line_no           = '0;
    held_r            = '0;
    held_g            = '0;
    src_gap_pct       = 8;
    snk_gap_pct       = 85;
    items_sent        = 0;
    items_taken       = 0;
    overflows         = 0;
    bytes_checked     = 0;
    frames_done       = 0;
    configs_loaded    = 0;
    mismatches        = 0;
    stall_cycles      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_tone_clamps();
    test_zero_sizes();
    test_config_mid_line();
    run_random_frames(130, 8, 85);
    run_random_frames(130, 85, 8);
    run_random_frames(130, 0, 0);
    settle();

    if (bgr_expected_q.size() != 0)
      report_mismatch("missing output bytes", 0, bgr_expected_q.size());
    $display("Sent %0d input bytes (%0d pixel or overflow, %0d overflow) over %0d settings.",
             items_sent, items_taken, overflows, configs_loaded);
    $display("Checked %0d output bytes, %0d frame ends, %0d mismatches.",
             bytes_checked, frames_done, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
